/* rtl/chgs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_pkg: shared types and constants of the convex hull block
// widths of coordinates, differences, accumulator and area, plus the
// operation word of the shared multiply-accumulate unit
// ----------------------------------------------------------------------------
package chgs_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W        = 20;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int ACC_W          = PROD_W + 8;
    localparam int AREA_W         = 43;
    localparam int COUNT_W        = 7;

    localparam logic [ACC_W-1:0] AREA_MAX = ACC_W'({AREA_W{1'b1}});

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic valid;
        logic clear;
        logic sub;
    } mac_op_t;

    function automatic logic signed [DIFF_W-1:0] coord_ext(
        input logic signed [COORD_W-1:0] a);
        return {a[COORD_W-1], a};
    endfunction

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

endpackage
`default_nettype wire

/* rtl/chgs_point_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_point_if: input point channel
// valid/ready handshake carrying one point item
// ----------------------------------------------------------------------------
interface chgs_point_if
    import chgs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface
`default_nettype wire

/* rtl/chgs_vertex_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_vertex_if: output hull vertex channel
// valid/ready handshake carrying one hull vertex item
// ----------------------------------------------------------------------------
interface chgs_vertex_if
    import chgs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
    logic [COUNT_W-1:0]        vertex_count;
    logic [AREA_W-1:0]         doubled_area;
    logic                      overflowed;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    output vertex_count, output doubled_area, output overflowed,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    input vertex_count, input doubled_area, input overflowed,
                    output ready);
endinterface
`default_nettype wire

/* rtl/convex_hull_graham_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// convex_hull_graham_scan: convex hull of a streamed point set
// Points enter one item at a time; the item flagged last_point closes the set.
// Each point item is first searched for a duplicate among the points stored
// so far, through the point memory. On the last item the block sorts the
// points around the pivot by insertion, about N*N/4 comparisons for N points,
// runs the scan, sums the shoelace area and then sends the hull vertex items
// one at a time, each held until the sink is ready. All products go through
// one pipelined multiply-accumulate unit and every table is a memory with a
// single read port. No point item is taken meanwhile.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan
    import chgs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    chgs_point_if.sink     pt,
    chgs_vertex_if.source  hull
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NS    = 43;

    typedef enum logic [NS-1:0] {
        S_IDLE     = NS'(1) << 0,
        S_DUP_RD   = NS'(1) << 1,
        S_DUP_CMP  = NS'(1) << 2,
        S_INS      = NS'(1) << 3,
        S_SO_NEXT  = NS'(1) << 4,
        S_SO_CUR   = NS'(1) << 5,
        S_SO_J     = NS'(1) << 6,
        S_SO_IDX   = NS'(1) << 7,
        S_SO_B     = NS'(1) << 8,
        S_SO_X0    = NS'(1) << 9,
        S_SO_X1    = NS'(1) << 10,
        S_SO_XW    = NS'(1) << 11,
        S_SO_D0    = NS'(1) << 12,
        S_SO_D1    = NS'(1) << 13,
        S_SO_D2    = NS'(1) << 14,
        S_SO_D3    = NS'(1) << 15,
        S_SO_DW    = NS'(1) << 16,
        S_SO_SHIFT = NS'(1) << 17,
        S_SO_PUT   = NS'(1) << 18,
        S_SC_INIT  = NS'(1) << 19,
        S_SC_RD    = NS'(1) << 20,
        S_SC_IDX   = NS'(1) << 21,
        S_SC_C     = NS'(1) << 22,
        S_SC_TEST  = NS'(1) << 23,
        S_SC_T1    = NS'(1) << 24,
        S_SC_TW    = NS'(1) << 25,
        S_SC_POP   = NS'(1) << 26,
        S_SC_PIDX  = NS'(1) << 27,
        S_SC_PS2   = NS'(1) << 28,
        S_SC_PUSH  = NS'(1) << 29,
        S_AR_INIT  = NS'(1) << 30,
        S_AR_RD    = NS'(1) << 31,
        S_AR_IDX   = NS'(1) << 32,
        S_AR_C     = NS'(1) << 33,
        S_AR_M0    = NS'(1) << 34,
        S_AR_M1    = NS'(1) << 35,
        S_AR_W0    = NS'(1) << 36,
        S_AR_W1    = NS'(1) << 37,
        S_AR_WAIT  = NS'(1) << 38,
        S_EM_RD    = NS'(1) << 39,
        S_EM_IDX   = NS'(1) << 40,
        S_EM_LD    = NS'(1) << 41,
        S_EM_WAIT  = NS'(1) << 42
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic             dup_reg, dup_next;
    logic             drop_reg, drop_next;
    logic             last_reg, last_next;
    point_t           in_reg, in_next;
    point_t           piv_reg, piv_next;
    logic [IDX_W-1:0] piv_idx_reg, piv_idx_next;
    logic [IDX_W-1:0] b_idx_reg, b_idx_next;
    logic [IDX_W-1:0] c_idx_reg, c_idx_next;
    logic signed [DIFF_W-1:0] adx_reg, adx_next, ady_reg, ady_next;
    logic signed [DIFF_W-1:0] bdx_reg, bdx_next, bdy_reg, bdy_next;
    point_t           s1_reg, s1_next, s2_reg, s2_next, c_reg, c_next;
    logic [AREA_W-1:0] area_reg, area_next;

    logic               ov_reg, ov_next;
    point_t             opt_reg, opt_next;
    logic               olast_reg, olast_next;

    point_t           store_mem [MAX_POINTS];
    logic [IDX_W-1:0] ord_mem   [MAX_POINTS];
    logic [IDX_W-1:0] stk_mem   [MAX_POINTS];

    logic             st_we, ord_we, stk_we;
    logic [IDX_W-1:0] st_waddr, ord_waddr, stk_waddr;
    logic [IDX_W-1:0] ord_wdata, stk_wdata;
    logic [IDX_W-1:0] st_raddr, ord_raddr, stk_raddr;
    point_t           st_rd_reg;
    logic [IDX_W-1:0] ord_rd_reg, stk_rd_reg;

    mac_op_t                  mac_op;
    logic signed [DIFF_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mac_busy;
    logic [ACC_W-1:0]         abs_acc;

    logic [CNT_W-1:0] j_m1, d_m3, i_p1, k_p1;

    chgs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= in_reg;
        end
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        st_rd_reg  <= store_mem[st_raddr];
        ord_rd_reg <= ord_mem[ord_raddr];
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign j_m1 = j_reg - CNT_W'(1);
    assign d_m3 = depth_reg - CNT_W'(3);
    assign i_p1 = i_reg + CNT_W'(1);
    assign k_p1 = k_reg + CNT_W'(1);
    assign abs_acc = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        depth_next   = depth_reg;
        dup_next     = dup_reg;
        drop_next    = drop_reg;
        last_next    = last_reg;
        in_next      = in_reg;
        piv_next     = piv_reg;
        piv_idx_next = piv_idx_reg;
        b_idx_next   = b_idx_reg;
        c_idx_next   = c_idx_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        bdx_next     = bdx_reg;
        bdy_next     = bdy_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        c_next       = c_reg;
        area_next    = area_reg;
        ov_next      = ov_reg;
        opt_next     = opt_reg;
        olast_next   = olast_reg;

        st_we     = 1'b0;
        ord_we    = 1'b0;
        stk_we    = 1'b0;
        st_waddr  = cnt_reg[IDX_W-1:0];
        ord_waddr = j_reg[IDX_W-1:0];
        ord_wdata = b_idx_reg;
        stk_waddr = depth_reg[IDX_W-1:0];
        stk_wdata = c_idx_reg;
        st_raddr  = k_reg[IDX_W-1:0];
        ord_raddr = i_reg[IDX_W-1:0];
        stk_raddr = k_reg[IDX_W-1:0];

        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (pt.valid)
                begin
                    in_next   = '{x: pt.point_x, y: pt.point_y};
                    last_next = pt.last_point;
                    dup_next  = 1'b0;
                    k_next    = '0;
                    state_next = S_DUP_RD;
                end
            end
            S_DUP_RD:
            begin
                st_raddr = k_reg[IDX_W-1:0];
                state_next = (k_reg == cnt_reg) ? S_INS : S_DUP_CMP;
            end
            S_DUP_CMP:
            begin
                if (st_rd_reg == in_reg)
                begin
                    dup_next = 1'b1;
                end
                k_next = k_p1;
                state_next = S_DUP_RD;
            end
            S_INS:
            begin
                if (!dup_reg)
                begin
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                    begin
                        st_we = 1'b1;
                        if (cnt_reg == '0 || in_reg.y < piv_reg.y ||
                            (in_reg.y == piv_reg.y && in_reg.x < piv_reg.x))
                        begin
                            piv_next     = in_reg;
                            piv_idx_next = cnt_reg[IDX_W-1:0];
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                i_next = '0;
                n_next = '0;
                state_next = last_reg ? S_SO_NEXT : S_IDLE;
            end
            S_SO_NEXT:
            begin
                st_raddr = i_reg[IDX_W-1:0];
                if (i_reg == cnt_reg)
                begin
                    state_next = S_SC_INIT;
                end
                else if (i_reg == CNT_W'(piv_idx_reg))
                begin
                    i_next = i_p1;
                end
                else
                begin
                    state_next = S_SO_CUR;
                end
            end
            S_SO_CUR:
            begin
                adx_next = coord_diff(st_rd_reg.x, piv_reg.x);
                ady_next = coord_diff(st_rd_reg.y, piv_reg.y);
                j_next   = n_reg;
                state_next = S_SO_J;
            end
            S_SO_J:
            begin
                ord_raddr = j_m1[IDX_W-1:0];
                state_next = (j_reg == '0) ? S_SO_PUT : S_SO_IDX;
            end
            S_SO_IDX:
            begin
                b_idx_next = ord_rd_reg;
                st_raddr   = ord_rd_reg;
                state_next = S_SO_B;
            end
            S_SO_B:
            begin
                bdx_next = coord_diff(st_rd_reg.x, piv_reg.x);
                bdy_next = coord_diff(st_rd_reg.y, piv_reg.y);
                state_next = S_SO_X0;
            end
            S_SO_X0:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
                mac_a  = adx_reg;
                mac_b  = bdy_reg;
                state_next = S_SO_X1;
            end
            S_SO_X1:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a  = ady_reg;
                mac_b  = bdx_reg;
                state_next = S_SO_XW;
            end
            S_SO_XW:
            begin
                if (!mac_busy)
                begin
                    if (mac_acc < 0)
                    begin
                        state_next = S_SO_SHIFT;
                    end
                    else if (mac_acc == '0)
                    begin
                        state_next = S_SO_D0;
                    end
                    else
                    begin
                        state_next = S_SO_PUT;
                    end
                end
            end
            S_SO_D0:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
                mac_a  = adx_reg;
                mac_b  = adx_reg;
                state_next = S_SO_D1;
            end
            S_SO_D1:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
                mac_a  = ady_reg;
                mac_b  = ady_reg;
                state_next = S_SO_D2;
            end
            S_SO_D2:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a  = bdx_reg;
                mac_b  = bdx_reg;
                state_next = S_SO_D3;
            end
            S_SO_D3:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a  = bdy_reg;
                mac_b  = bdy_reg;
                state_next = S_SO_DW;
            end
            S_SO_DW:
            begin
                if (!mac_busy)
                begin
                    state_next = (mac_acc < 0) ? S_SO_SHIFT : S_SO_PUT;
                end
            end
            S_SO_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[IDX_W-1:0];
                ord_wdata = b_idx_reg;
                j_next    = j_m1;
                state_next = S_SO_J;
            end
            S_SO_PUT:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[IDX_W-1:0];
                ord_wdata = i_reg[IDX_W-1:0];
                n_next    = n_reg + CNT_W'(1);
                i_next    = i_p1;
                state_next = S_SO_NEXT;
            end
            S_SC_INIT:
            begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = piv_idx_reg;
                depth_next = CNT_W'(1);
                s1_next    = piv_reg;
                i_next     = '0;
                state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                ord_raddr = i_reg[IDX_W-1:0];
                state_next = (i_reg == n_reg) ? S_AR_INIT : S_SC_IDX;
            end
            S_SC_IDX:
            begin
                c_idx_next = ord_rd_reg;
                st_raddr   = ord_rd_reg;
                state_next = S_SC_C;
            end
            S_SC_C:
            begin
                c_next = st_rd_reg;
                state_next = S_SC_TEST;
            end
            S_SC_TEST:
            begin
                if (depth_reg >= CNT_W'(2))
                begin
                    mac_op = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a  = coord_diff(s1_reg.x, s2_reg.x);
                    mac_b  = coord_diff(c_reg.y, s1_reg.y);
                    state_next = S_SC_T1;
                end
                else
                begin
                    state_next = S_SC_PUSH;
                end
            end
            S_SC_T1:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a  = coord_diff(s1_reg.y, s2_reg.y);
                mac_b  = coord_diff(c_reg.x, s1_reg.x);
                state_next = S_SC_TW;
            end
            S_SC_TW:
            begin
                if (!mac_busy)
                begin
                    state_next = (mac_acc >= 0) ? S_SC_POP : S_SC_PUSH;
                end
            end
            S_SC_POP:
            begin
                depth_next = depth_reg - CNT_W'(1);
                s1_next    = s2_reg;
                stk_raddr  = d_m3[IDX_W-1:0];
                state_next = (depth_reg >= CNT_W'(3)) ? S_SC_PIDX : S_SC_TEST;
            end
            S_SC_PIDX:
            begin
                st_raddr = stk_rd_reg;
                state_next = S_SC_PS2;
            end
            S_SC_PS2:
            begin
                s2_next = st_rd_reg;
                state_next = S_SC_TEST;
            end
            S_SC_PUSH:
            begin
                if (depth_reg < CNT_W'(MAX_POINTS))
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[IDX_W-1:0];
                    stk_wdata  = c_idx_reg;
                    depth_next = depth_reg + CNT_W'(1);
                    s2_next    = s1_reg;
                    s1_next    = c_reg;
                end
                i_next = i_p1;
                state_next = S_SC_RD;
            end
            S_AR_INIT:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
                k_next = '0;
                state_next = S_AR_RD;
            end
            S_AR_RD:
            begin
                stk_raddr = k_reg[IDX_W-1:0];
                state_next = (k_reg == depth_reg) ? S_AR_W0 : S_AR_IDX;
            end
            S_AR_IDX:
            begin
                st_raddr = stk_rd_reg;
                state_next = S_AR_C;
            end
            S_AR_C:
            begin
                c_next = st_rd_reg;
                if (k_reg == '0)
                begin
                    s1_next = st_rd_reg;
                    s2_next = st_rd_reg;
                    k_next  = k_p1;
                    state_next = S_AR_RD;
                end
                else
                begin
                    state_next = S_AR_M0;
                end
            end
            S_AR_M0:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
                mac_a  = coord_ext(s1_reg.x);
                mac_b  = coord_ext(c_reg.y);
                state_next = S_AR_M1;
            end
            S_AR_M1:
            begin
                mac_op  = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a   = coord_ext(c_reg.x);
                mac_b   = coord_ext(s1_reg.y);
                s1_next = c_reg;
                k_next  = k_p1;
                state_next = S_AR_RD;
            end
            S_AR_W0:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
                mac_a  = coord_ext(s1_reg.x);
                mac_b  = coord_ext(s2_reg.y);
                state_next = S_AR_W1;
            end
            S_AR_W1:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
                mac_a  = coord_ext(s2_reg.x);
                mac_b  = coord_ext(s1_reg.y);
                state_next = S_AR_WAIT;
            end
            S_AR_WAIT:
            begin
                if (!mac_busy)
                begin
                    area_next = (abs_acc > AREA_MAX) ? AREA_MAX[AREA_W-1:0]
                                                     : abs_acc[AREA_W-1:0];
                    k_next = '0;
                    state_next = S_EM_RD;
                end
            end
            S_EM_RD:
            begin
                stk_raddr = k_reg[IDX_W-1:0];
                state_next = S_EM_IDX;
            end
            S_EM_IDX:
            begin
                st_raddr = stk_rd_reg;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                ov_next    = 1'b1;
                opt_next   = st_rd_reg;
                olast_next = (k_p1 == depth_reg);
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (hull.ready)
                begin
                    ov_next = 1'b0;
                    k_next  = k_p1;
                    if (olast_reg)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        piv_next   = '0;
                        depth_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            depth_reg <= '0;
            drop_reg  <= 1'b0;
            piv_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
            drop_reg  <= drop_next;
            piv_reg   <= piv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        dup_reg     <= dup_next;
        last_reg    <= last_next;
        in_reg      <= in_next;
        piv_idx_reg <= piv_idx_next;
        b_idx_reg   <= b_idx_next;
        c_idx_reg   <= c_idx_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        bdx_reg     <= bdx_next;
        bdy_reg     <= bdy_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        c_reg       <= c_next;
        area_reg    <= area_next;
        opt_reg     <= opt_next;
        olast_reg   <= olast_next;
    end

    assign pt.ready          = (state_reg == S_IDLE);
    assign hull.valid        = ov_reg;
    assign hull.vertex_x     = opt_reg.x;
    assign hull.vertex_y     = opt_reg.y;
    assign hull.last_vertex  = olast_reg;
    assign hull.vertex_count = COUNT_W'(depth_reg);
    assign hull.doubled_area = area_reg;
    assign hull.overflowed   = drop_reg;

endmodule
`default_nettype wire

/* rtl/chgs_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_mac: shared multiply-accumulate unit
// operand register, product register, accumulator; an op may clear the
// accumulator and may add or subtract its product
// ----------------------------------------------------------------------------
module chgs_mac
    import chgs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_op_t                  op,
    input  wire logic signed [DIFF_W-1:0] a,
    input  wire logic signed [DIFF_W-1:0] b,
    output logic signed [ACC_W-1:0]       acc,
    output logic                          busy
);

    logic                     v1_reg, v2_reg;
    logic                     clr1_reg, sub1_reg, clr2_reg, sub2_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= op.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        clr1_reg <= op.clear;
        sub1_reg <= op.sub;
        a1_reg   <= a;
        b1_reg   <= b;
        clr2_reg <= clr1_reg;
        sub2_reg <= sub1_reg;
        prod_reg <= a1_reg * b1_reg;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        base     = clr2_reg ? '0 : acc_reg;
        prod_ext = ACC_W'(prod_reg);
        acc_next = acc_reg;
        if (v2_reg)
        begin
            acc_next = sub2_reg ? base - prod_ext : base + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule
`default_nettype wire
